@@ design/desa_pkg.sv @@
// Shared types and constants for the double-ended stack allocator.
// Holds the command codes, the input and result word layouts and the marker state.
// No dependencies.
`default_nettype none

package desa_pkg;

  // Offset and field widths
  localparam int unsigned OffW      = 21;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned CmdW      = 3;

  // Default region addressing width and capacity out of reset
  localparam int unsigned  CapacityBitsDefault = 20;
  localparam logic [OffW-1:0] CapResetValue    = 21'd1048576;

  // Commands
  typedef enum logic [CmdW-1:0] {
    CmdAllocTop      = 3'd0,
    CmdAllocBottom   = 3'd1,
    CmdReleaseTop    = 3'd2,
    CmdReleaseBottom = 3'd3,
    CmdRestoreTop    = 3'd4,
    CmdRestoreBottom = 3'd5,
    CmdClearTop      = 3'd6,
    CmdClearBottom   = 3'd7
  } cmd_e;

  // Input word
  typedef struct packed {
    cmd_e              cmd;
    logic [OffW-1:0]   alloc_size;
    logic [ShiftW-1:0] align_shift;
    logic [OffW-1:0]   marker;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic            ok;
    logic [OffW-1:0] block_offset;
    logic [OffW-1:0] top_now;
    logic [OffW-1:0] bottom_now;
  } out_word_t;

  // Both stack markers
  typedef struct packed {
    logic [OffW-1:0] top;
    logic [OffW-1:0] bottom;
  } marks_t;

endpackage

`default_nettype wire

@@ design/desa_exec.sv @@
// Command evaluation for the double-ended stack allocator.
// Purely combinational: takes one registered command and the markers, gives
// the new markers and the result word. Depends on desa_pkg.
`default_nettype none

module desa_exec (
  input  desa_pkg::in_word_t        word_i,
  input  logic [desa_pkg::OffW-1:0] cap_i,
  input  desa_pkg::marks_t          marks_i,
  output desa_pkg::marks_t          marks_o,
  output desa_pkg::out_word_t       res_o
);

  localparam int unsigned W = desa_pkg::OffW;

  logic [W-1:0] amask;
  logic         shift_big;
  logic         sized;
  logic [W-1:0] top_diff;
  logic [W-1:0] top_start;
  logic         top_fail;
  logic [W:0]   bot_sum;
  logic [W:0]   bot_start;
  logic [W+1:0] bot_end;
  logic         bot_fail;
  logic [W-1:0] room;
  logic         ok;
  logic [W-1:0] block;
  desa_pkg::marks_t nxt;

  // Alignment mask; shifts past the offset width clear every bit
  assign shift_big = (word_i.align_shift >= desa_pkg::ShiftW'(W));
  assign amask     = shift_big ? '1 : ((W'(1) << word_i.align_shift) - W'(1));

  assign sized = (word_i.cmd == desa_pkg::CmdAllocTop)    ||
                 (word_i.cmd == desa_pkg::CmdAllocBottom) ||
                 (word_i.cmd == desa_pkg::CmdReleaseTop)  ||
                 (word_i.cmd == desa_pkg::CmdReleaseBottom);

  // Top allocation: align the start down
  assign top_diff  = marks_i.top - word_i.alloc_size;
  assign top_start = top_diff & ~amask;
  assign top_fail  = (word_i.alloc_size > marks_i.top) || (top_start <= marks_i.bottom);

  // Bottom allocation: align the start up; a huge alignment off a non-zero
  // bottom always lands beyond the region
  assign bot_sum   = {1'b0, marks_i.bottom} + {1'b0, amask};
  assign bot_start = shift_big ? '0 : (bot_sum & ~{1'b0, amask});
  assign bot_end   = {1'b0, bot_start} + {2'b00, word_i.alloc_size};
  assign bot_fail  = (shift_big && (marks_i.bottom != '0)) ||
                     (bot_end >= {2'b00, marks_i.top});

  // Space left above the top marker
  assign room = cap_i - marks_i.top;

  // Apply the command
  always_comb begin
    nxt   = marks_i;
    ok    = 1'b1;
    block = '0;
    if (sized && (word_i.alloc_size == '0)) begin
      ok = 1'b0;
    end else begin
      case (word_i.cmd)
        desa_pkg::CmdAllocTop: begin
          if (top_fail) begin
            ok = 1'b0;
          end else begin
            nxt.top = top_start;
            block   = top_start;
          end
        end
        desa_pkg::CmdAllocBottom: begin
          if (bot_fail) begin
            ok = 1'b0;
          end else begin
            nxt.bottom = bot_end[W-1:0];
            block      = bot_start[W-1:0];
          end
        end
        desa_pkg::CmdReleaseTop: begin
          nxt.top = (word_i.alloc_size > room) ? cap_i : (marks_i.top + word_i.alloc_size);
        end
        desa_pkg::CmdReleaseBottom: begin
          nxt.bottom = (word_i.alloc_size > marks_i.bottom) ? '0
                     : (marks_i.bottom - word_i.alloc_size);
        end
        desa_pkg::CmdRestoreTop: begin
          if ((word_i.marker > marks_i.top) && (word_i.marker < cap_i)) begin
            nxt.top = word_i.marker;
          end
        end
        desa_pkg::CmdRestoreBottom: begin
          if (word_i.marker < marks_i.bottom) begin
            nxt.bottom = word_i.marker;
          end
        end
        desa_pkg::CmdClearTop: begin
          nxt.top = cap_i;
        end
        desa_pkg::CmdClearBottom: begin
          nxt.bottom = '0;
        end
        default: begin
          nxt = marks_i;
        end
      endcase
    end
  end

  assign marks_o            = nxt;
  assign res_o.ok           = ok;
  assign res_o.block_offset = block;
  assign res_o.top_now      = nxt.top;
  assign res_o.bottom_now   = nxt.bottom;

endmodule

`default_nettype wire

@@ design/double_ended_stack_allocator.sv @@
// Top level of the double-ended stack allocator: input register, markers,
// capacity register and result register. Depends on desa_pkg and desa_exec.
//
//   channel  direction  handshake                 word
//   in       sink       in_valid_i / in_stall_o   in_word_i   (desa_pkg::in_word_t)
//   out      source     out_valid_o / out_stall_i out_word_o  (desa_pkg::out_word_t)
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i  (capacity, 21 bits)
//
// One word per cycle sustained while out_stall_i is low; a taken word goes through the
// input register, then one evaluation stage into the result register, where it is offered.
// The markers update as a word moves into the result register, so the next word sees them.
// Reset sets capacity to its default, top to capacity and bottom to zero.
// A stalled result holds while the input register takes one more word.
// Capacity writes are taken only while both registers are empty.
`default_nettype none

module double_ended_stack_allocator #(
  parameter int unsigned CAPACITY_BITS = desa_pkg::CapacityBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  desa_pkg::in_word_t        in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output desa_pkg::out_word_t       out_word_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [desa_pkg::OffW-1:0] cfg_data_i
);

  localparam int unsigned W = desa_pkg::OffW;
  localparam logic [W-1:0] CapLimit = (CAPACITY_BITS >= W) ? {W{1'b1}}
                                    : W'(64'd1 << CAPACITY_BITS);
  localparam logic [W-1:0] CapReset = (desa_pkg::CapResetValue > CapLimit) ? CapLimit
                                    : desa_pkg::CapResetValue;

  logic                a_valid_q;
  desa_pkg::in_word_t  a_word_q;
  logic                b_valid_q;
  desa_pkg::out_word_t b_word_q;
  logic [W-1:0]        cap_q;
  desa_pkg::marks_t    marks_q;
  desa_pkg::marks_t    marks_d;
  desa_pkg::out_word_t res;
  logic                b_free;
  logic                a_fire;
  logic                in_take;
  logic                cfg_take;
  logic [W-1:0]        cap_floor;
  logic [W-1:0]        cap_d;

  // Handshake
  assign b_free      = !b_valid_q || !out_stall_i;
  assign a_fire      = a_valid_q && b_free;
  assign in_stall_o  = a_valid_q && !b_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !a_valid_q && !b_valid_q;
  assign cfg_take    = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = b_valid_q;
  assign out_word_o  = b_word_q;

  // Clamp a written capacity into range
  assign cap_floor = (cfg_data_i == '0) ? W'(1) : cfg_data_i;
  assign cap_d     = (cap_floor > CapLimit) ? CapLimit : cap_floor;

  desa_exec u_exec (
    .word_i  (a_word_q),
    .cap_i   (cap_q),
    .marks_i (marks_q),
    .marks_o (marks_d),
    .res_o   (res)
  );

  // Stage valids, capacity and markers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q      <= 1'b0;
      b_valid_q      <= 1'b0;
      cap_q          <= CapReset;
      marks_q.top    <= CapReset;
      marks_q.bottom <= '0;
    end else begin
      if (in_take) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        b_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        b_valid_q <= 1'b0;
      end
      if (cfg_take) begin
        cap_q          <= cap_d;
        marks_q.top    <= cap_d;
        marks_q.bottom <= '0;
      end else if (a_fire) begin
        marks_q <= marks_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_word_q <= in_word_i;
    end
    if (a_fire) begin
      b_word_q <= res;
    end
  end

endmodule

`default_nettype wire

@@ design/desa_checker.sv @@
// Port-level checks for the double-ended stack allocator, bound to the top level.
// Depends on desa_pkg and double_ended_stack_allocator.
`default_nettype none

module desa_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input desa_pkg::out_word_t       out_word_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

  // Refused commands grant no block
  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.ok |-> out_word_o.block_offset == '0)
    else $error("block offset on a refused command");

  // Stacks never meet
  a_marks_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.bottom_now < out_word_o.top_now)
    else $error("bottom marker reached top marker");

  // Capacity writes only while idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !out_valid_o)
    else $error("capacity write taken while a result is pending");

endmodule

bind double_ended_stack_allocator desa_checker u_desa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
